### rtl/tcmt_pkg.sv
package tcmt_pkg;

  localparam int unsigned CONTACTS = 10;
  localparam int unsigned CI_W     = 4;

  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned OUT_TUSER_W = 3;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [7:0] HOVER_THRESHOLD_RST = 8'd6;

  // result kind, carried on tuser
  typedef enum logic [2:0] {
    KIND_SCREEN    = 3'd0,
    KIND_CONTACT   = 3'd1,
    KIND_SELF_TEST = 3'd2,
    KIND_COMMAND   = 3'd3,
    KIND_UNHANDLED = 3'd4
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_ID        = 3'd0,
    CFG_FIRST_CONTACT_ID = 3'd1,
    CFG_CONTACTS_IN_USE  = 3'd2,
    CFG_SELF_TEST_ID     = 3'd3,
    CFG_COMMAND_ID       = 3'd4,
    CFG_SELF_TEST_PRES   = 3'd5,
    CFG_HOVER_THRESHOLD  = 3'd6
  } cfg_idx_e;

  // contact event codes (byte 0, bits 3..0)
  localparam logic [3:0] EV_MOVE        = 4'd1;
  localparam logic [3:0] EV_UNSUP       = 4'd2;
  localparam logic [3:0] EV_SUP         = 4'd3;
  localparam logic [3:0] EV_DOWN        = 4'd4;
  localparam logic [3:0] EV_UP          = 4'd5;
  localparam logic [3:0] EV_UNSUP_SUP   = 4'd6;
  localparam logic [3:0] EV_UNSUP_UP    = 4'd7;
  localparam logic [3:0] EV_DOWN_SUP    = 4'd8;

  // contact type codes (byte 0, bits 6..4)
  localparam logic [2:0] TY_FINGER = 3'd1;
  localparam logic [2:0] TY_STYLUS = 3'd2;

  localparam logic [1:0] TOOL_UNKNOWN = 2'd0;

  localparam int unsigned CMD_RESET_BIT = 7;

  typedef struct packed {
    logic [1:0]  tool;
    logic        tip;
    logic        in_view;
    logic        conf;
    logic [15:0] x;
    logic [15:0] y;
  } contact_rec_t;

  // decoded contact message handed to the record update
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] byte4;
    logic [7:0] byte5;
  } msg_bytes_t;

endpackage

### rtl/tcmt_contact_update.sv
module tcmt_contact_update
  import tcmt_pkg::*;
(
  input  contact_rec_t rec_i,
  input  msg_bytes_t   msg_i,
  input  logic [7:0]   hover_threshold_i,
  output contact_rec_t rec_o
);

  logic [3:0] ev;
  logic [2:0] ty;
  logic       pos_upd;

  assign ev = msg_i.byte0[3:0];
  assign ty = msg_i.byte0[6:4];

  assign pos_upd = (ev == EV_MOVE) || (ev == EV_DOWN) || (ev == EV_DOWN_SUP) ||
                   (ev == EV_UP) || (ev == EV_UNSUP_UP) || (ev == EV_UNSUP);

  always_comb begin
    rec_o          = rec_i;
    rec_o.tool     = ((ty == TY_FINGER) || (ty == TY_STYLUS)) ? ty[1:0] : TOOL_UNKNOWN;
    rec_o.in_view  = 1'b1;
    // unknown types leave the tip alone
    if (ty == TY_FINGER) begin
      if ((ev == EV_DOWN) || (ev == EV_MOVE)) rec_o.tip = 1'b1;
    end else if (ty == TY_STYLUS) begin
      rec_o.tip = (msg_i.byte5 > hover_threshold_i);
    end
    // lift events win over any press
    if ((ev == EV_UP) || (ev == EV_UNSUP_SUP)) rec_o.tip = 1'b0;
    if (pos_upd) begin
      rec_o.x = {msg_i.byte2, msg_i.byte1};
      rec_o.y = {msg_i.byte4, msg_i.byte3};
    end
    rec_o.conf = !((ev == EV_SUP) || (ev == EV_UNSUP_SUP) || (ev == EV_DOWN_SUP));
  end

endmodule

### rtl/touch_contact_message_tracker_core.sv
// Touch contact message tracker. Each input beat is one controller message
// (message id plus six data bytes); each output beat is one classified result.
// The id is matched in priority order against the screen-status id, the
// self-test id, the contact id range (first contact id onward,
// contacts_in_use ids, capped at CONTACTS, none when zero) and the command id;
// anything else is reported as unhandled with its status byte. A screen
// message with zero fingers clears tool, tip, in-range and confidence of all
// contacts. Contact messages update a per-contact record held in flops and
// return the updated record. Timing: one message per clock while the output
// is not back-pressured; a message lands in the input register, the record
// update and classification are done in combinational logic after it, and
// the result is then registered in the output register, together with the
// table read-modify-write, so back-to-back messages to the same contact see
// each other's updates. Configuration writes take effect on the next edge
// and are expected only while the block is idle. No clearing pass: reset
// clears the table at once.
module touch_contact_message_tracker_core
  import tcmt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,

  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [7:0] message id, [15:8] byte0, [23:16] byte1, [31:24] byte2,
  // [39:32] byte3, [47:40] byte4, [55:48] byte5
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,

  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [3:0] contact_index, [5:4] tool_kind, [6] tip_down, [7] in_range_flag,
  // [8] confident, [24:9] pos_x, [40:25] pos_y, [41] all_cleared,
  // [42] run_self_test, [50:43] status_byte, [55:51] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // [2:0] kind
  output logic [OUT_TUSER_W-1:0] m_axis_tuser
);

  // configuration registers
  logic [7:0] screen_id_q, first_id_q, self_test_id_q, command_id_q, hover_thr_q;
  logic [3:0] contacts_in_use_q;
  logic       self_test_pres_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_id_q       <= '0;
      first_id_q        <= '0;
      contacts_in_use_q <= '0;
      self_test_id_q    <= '0;
      command_id_q      <= '0;
      self_test_pres_q  <= 1'b0;
      hover_thr_q       <= HOVER_THRESHOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SCREEN_ID:        screen_id_q       <= cfg_wdata_i;
        CFG_FIRST_CONTACT_ID: first_id_q        <= cfg_wdata_i;
        CFG_CONTACTS_IN_USE:  contacts_in_use_q <= cfg_wdata_i[3:0];
        CFG_SELF_TEST_ID:     self_test_id_q    <= cfg_wdata_i;
        CFG_COMMAND_ID:       command_id_q      <= cfg_wdata_i;
        CFG_SELF_TEST_PRES:   self_test_pres_q  <= cfg_wdata_i[0];
        CFG_HOVER_THRESHOLD:  hover_thr_q       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pipeline control: input register, then result register
  logic s1_valid_q, out_valid_q, advance;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || advance;

  logic [7:0] id_q;
  msg_bytes_t msg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) s1_valid_q  <= s_axis_tvalid;
      if (advance)       out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      id_q  <= s_axis_tdata[7:0];
      msg_q <= {s_axis_tdata[15:8], s_axis_tdata[23:16], s_axis_tdata[31:24],
                s_axis_tdata[39:32], s_axis_tdata[47:40], s_axis_tdata[55:48]};
    end
  end

  // classification
  logic [3:0]      n_used;
  logic [7:0]      id_diff;
  logic            contact_hit;
  logic [CI_W-1:0] ci;

  assign n_used       = (contacts_in_use_q > CI_W'(CONTACTS)) ? CI_W'(CONTACTS)
                                                               : contacts_in_use_q;
  assign id_diff      = id_q - first_id_q;
  assign contact_hit  = (n_used != '0) && (id_q >= first_id_q) &&
                        (id_diff < {4'd0, n_used});
  assign ci           = id_diff[CI_W-1:0];

  kind_e kind;

  always_comb begin
    priority if (id_q == screen_id_q) kind = KIND_SCREEN;
    else if (id_q == self_test_id_q)  kind = KIND_SELF_TEST;
    else if (contact_hit)             kind = KIND_CONTACT;
    else if (id_q == command_id_q)    kind = KIND_COMMAND;
    else                              kind = KIND_UNHANDLED;
  end

  // contact table
  contact_rec_t table_q [CONTACTS];
  contact_rec_t rec_new;
  logic         clear_all;
  logic         fire;

  assign fire      = s1_valid_q && advance;
  assign clear_all = (kind == KIND_SCREEN) && (msg_q.byte1 == 8'd0);

  tcmt_contact_update u_update (
    .rec_i             (table_q[ci]),
    .msg_i             (msg_q),
    .hover_threshold_i (hover_thr_q),
    .rec_o             (rec_new)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CONTACTS; k++) table_q[k] <= '0;
    end else if (fire) begin
      if (clear_all) begin
        for (int k = 0; k < CONTACTS; k++) begin
          table_q[k].tool     <= TOOL_UNKNOWN;
          table_q[k].tip      <= 1'b0;
          table_q[k].in_view  <= 1'b0;
          table_q[k].conf     <= 1'b0;
        end
      end else if (kind == KIND_CONTACT) begin
        table_q[ci] <= rec_new;
      end
    end
  end

  // result assembly
  logic [OUT_TDATA_W-1:0] res_d, res_q;
  kind_e                  kind_q;
  contact_rec_t           rec_out;
  logic [7:0]             status_d;
  logic                   run_st_d;

  always_comb begin
    rec_out  = (kind == KIND_CONTACT) ? rec_new : '0;
    status_d = ((kind == KIND_SELF_TEST) || (kind == KIND_COMMAND) ||
                (kind == KIND_UNHANDLED)) ? msg_q.byte0 : 8'd0;
    run_st_d = (kind == KIND_COMMAND) && self_test_pres_q && msg_q.byte0[CMD_RESET_BIT];
    res_d    = {5'd0, status_d, run_st_d, clear_all, rec_out.y, rec_out.x,
                rec_out.conf, rec_out.in_view, rec_out.tip, rec_out.tool,
                (kind == KIND_CONTACT) ? ci : CI_W'(0)};
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q  <= res_d;
      kind_q <= kind;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;
  assign m_axis_tuser  = kind_q;

`ifndef ASSERT_OFF
  a_ready_only_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (s1_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a stalled output");

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> s1_valid_q)
    else $error("accepted beat missing from input register");

  a_contact_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != KIND_CONTACT)) |-> (m_axis_tdata[40:0] == '0))
    else $error("contact fields set on non-contact result");

  a_cleared_only_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[41]) |-> (m_axis_tuser == KIND_SCREEN))
    else $error("all_cleared on non-screen result");

  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (kind == KIND_CONTACT)) |-> ({4'd0, ci} < 8'(CONTACTS)))
    else $error("contact index beyond table");
`endif

endmodule
